@@ rtl/txrb_pkg.sv @@
// ----------------------------------------------------------------------------
// txrb_pkg: shared types and constants for the transmit ring buffer feeder
//
// Ring and FIFO sizes, pointer widths, operation codes and the transfer
// payload structs used by the sequencer, the ring memory and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package txrb_pkg;

  // Sizes
  localparam int RING_DEPTH  = 512;
  localparam int FIFO_DEPTH  = 8;
  localparam int MAX_RESULTS = 8;

  // Derived widths
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FREE_W = $clog2(FIFO_DEPTH + 16);   // holds FIFO_DEPTH and any count
  localparam int NUM_W  = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W  = PTR_W + FREE_W + NUM_W;    // common compare width

  // Field widths fixed by the interface
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;
  localparam int QCNT_W = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL = 2'd1;
  localparam logic [OP_W-1:0] OP_IRQ  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  fifo_count;
  } in_item_t;

  typedef struct packed {
    logic              fifo_write;
    logic [BYTE_W-1:0] fifo_byte;
    logic              last_result;
    logic              dropped;
    logic              irq_enabled;
    logic [QCNT_W-1:0] queued_count;
  } out_item_t;

  // Ring memory request from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/txrb_ring_mem.sv @@
// ----------------------------------------------------------------------------
// txrb_ring_mem: ring storage
//
// One write port and one read port; read data is registered and held
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module txrb_ring_mem (
  input  wire logic                      clk,
  input  wire txrb_pkg::mem_req_t        req,
  output logic [txrb_pkg::BYTE_W-1:0]    rd_data
);
  import txrb_pkg::*;

  logic [BYTE_W-1:0] mem [RING_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/txrb_seq.sv @@
// ----------------------------------------------------------------------------
// txrb_seq: item sequencer
//
// Takes one item at a time, works out the bytes to move and the final
// enable and fill level, then steps through the ring one byte per pass
// using a single shared pointer incrementer.
// ----------------------------------------------------------------------------
`default_nettype none

module txrb_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire txrb_pkg::in_item_t        in_item,
  input  wire logic                      out_free,
  output logic                           load,
  output txrb_pkg::out_item_t            load_item,
  output txrb_pkg::mem_req_t             mem_req,
  input  wire logic [txrb_pkg::BYTE_W-1:0] rd_data
);
  import txrb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_RD, S_DRAIN} state_t;

  state_t            state;
  in_item_t          item;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic              irq;
  logic [PTR_W-1:0]  q_fin;
  logic [NUM_W-1:0]  remain;

  logic [PTR_W-1:0]  inc_in;
  logic [PTR_W-1:0]  inc_out;
  logic [PTR_W-1:0]  used;
  logic [FREE_W-1:0] cnt_ext;
  logic              room;
  logic [FREE_W-1:0] free;
  logic [CMP_W-1:0]  lim;
  logic [NUM_W-1:0]  n;
  logic              ring_full;
  logic              is_drain;
  logic              irq_fin;
  logic              in_accept;
  out_item_t         stat_item;
  out_item_t         drain_item;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);

  // Shared pointer incrementer: write pointer while deciding, read pointer while draining
  assign inc_in  = (state == S_CALC) ? wp : rp;
  assign inc_out = (inc_in == PTR_W'(RING_DEPTH - 1)) ? '0 : inc_in + 1'b1;

  // Fill level and move count
  always_comb begin
    used = PTR_W'({1'b0, wp} + ((wp < rp) ? (PTR_W + 1)'(RING_DEPTH) : '0) - {1'b0, rp});
    cnt_ext = FREE_W'(item.fifo_count);
    room    = cnt_ext < FREE_W'(FIFO_DEPTH);
    free    = room ? FREE_W'(FIFO_DEPTH) - cnt_ext : '0;
    lim     = CMP_W'(used);
    if (CMP_W'(free) < lim) begin
      lim = CMP_W'(free);
    end
    if (CMP_W'(MAX_RESULTS) < lim) begin
      lim = CMP_W'(MAX_RESULTS);
    end
    n         = NUM_W'(lim);
    ring_full = (inc_out == rp);
    is_drain  = (item.opcode == OP_POLL) || (item.opcode == OP_IRQ);
    if (item.opcode == OP_POLL) begin
      irq_fin = (used != PTR_W'(n)) ? 1'b1 : irq;
    end else if (item.opcode == OP_IRQ) begin
      irq_fin = (used == PTR_W'(n)) ? 1'b0 : irq;
    end else begin
      irq_fin = irq;
    end
  end

  // Result payloads: single status/put result, and one drained byte
  always_comb begin
    stat_item              = '0;
    stat_item.last_result  = 1'b1;
    stat_item.irq_enabled  = irq_fin;
    stat_item.queued_count = QCNT_W'(used);
    if (item.opcode == OP_PUT) begin
      if (room) begin
        stat_item.fifo_write = 1'b1;
        stat_item.fifo_byte  = item.data_byte;
      end else if (ring_full) begin
        stat_item.dropped = 1'b1;
      end else begin
        stat_item.irq_enabled  = 1'b1;
        stat_item.queued_count = QCNT_W'(used + 1'b1);
      end
    end

    drain_item              = '0;
    drain_item.fifo_write   = 1'b1;
    drain_item.fifo_byte    = rd_data;
    drain_item.last_result  = (remain == NUM_W'(1));
    drain_item.irq_enabled  = irq;
    drain_item.queued_count = QCNT_W'(q_fin);
  end

  // Ring memory requests
  always_comb begin
    mem_req         = '0;
    mem_req.rd_addr = rp;
    mem_req.wr_addr = wp;
    mem_req.wr_data = item.data_byte;
    mem_req.wr_en   = (state == S_CALC) && out_free && (item.opcode == OP_PUT)
                      && !room && !ring_full;
    mem_req.rd_en   = ((state == S_CALC) && is_drain && (n != '0)) || (state == S_RD);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      rp     <= '0;
      irq    <= 1'b0;
      remain <= '0;
      load   <= 1'b0;
    end else begin
      load <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            item  <= in_item;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (is_drain && (n != '0)) begin
            irq    <= irq_fin;
            q_fin  <= used - PTR_W'(n);
            remain <= n;
            state  <= S_DRAIN;
          end else if (out_free) begin
            load      <= 1'b1;
            load_item <= stat_item;
            irq       <= stat_item.irq_enabled;
            // queued put advances the write pointer
            if ((item.opcode == OP_PUT) && !room && !ring_full) begin
              wp <= inc_out;
            end
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (out_free) begin
            load      <= 1'b1;
            load_item <= drain_item;
            rp        <= inc_out;
            remain    <= remain - 1'b1;
            state     <= (remain == NUM_W'(1)) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_drain_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (rp != wp))
    else $error("drain step with empty ring");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (inc_out != rp))
    else $error("ring write while ring full");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_CALC))
    else $error("accepted item did not start");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DRAIN) && out_free && (remain == NUM_W'(1))) |=>
      ((state == S_IDLE) && load && load_item.last_result))
    else $error("final drain transfer did not close the item");

endmodule

`default_nettype wire

@@ rtl/tx_ring_buffer_fifo_feeder_core.sv @@
// ----------------------------------------------------------------------------
// tx_ring_buffer_fifo_feeder_core: transmit ring buffer feeding a UART FIFO
//
// Puts go straight to the FIFO when it has room, else into the ring, or are
// dropped if the ring is full; poll and interrupt items drain ring bytes into the FIFO.
//
//   channel | direction | payload    | handshake
//   req     | in        | in_item_t  | req_valid / req_stall
//   rsp     | out       | out_item_t | rsp_valid / rsp_stall
//
// Put, status and empty drains load their result from the decide step.
// A drain has one decide step that also reads the first byte; each byte is
// then one output load, with one ring read before each further byte, paced
// by the single read port. A stalled output holds a load until it is free.
// One item is in work at a time; the next is taken once the last result
// is loaded into the output register, even if that result is still stalled.
// Reset clears pointers and the interrupt enable; the ring needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_ring_buffer_fifo_feeder_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire txrb_pkg::in_item_t    req_item,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output txrb_pkg::out_item_t        rsp_item
);
  import txrb_pkg::*;

  logic              out_free;
  logic              load;
  out_item_t         load_item;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rd_data;

  assign out_free = !rsp_valid || !rsp_stall;

  txrb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .in_item   (req_item),
    .out_free  (out_free),
    .load      (load),
    .load_item (load_item),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  txrb_ring_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: holds a result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_item <= load_item;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_tx_ring_buffer_fifo_feeder_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tx_ring_buffer_fifo_feeder_core: self-checking bench for the TX ring feeder
//
// Drives put, poll, interrupt and unused requests through the request channel
// and checks every response transfer against a shadow copy of the ring, its
// pointers and the interrupt enable. Covers direct FIFO writes, queueing,
// drains up to the per-request limit, a full ring with drops, a long response
// hold-off that backs up the request side, and random traffic with bursty
// request timing and patterned response stalls.
// ----------------------------------------------------------------------------

module tb_tx_ring_buffer_fifo_feeder_core;

  import txrb_pkg::*;

  localparam int                CLK_HALF       = 6;
  localparam int                RESET_CYCLES   = 12;
  localparam int                RANDOM_ITEMS   = 380;
  localparam int                HOLD_CYCLES    = 400;
  localparam int                WATCHDOG_LIMIT = 3000;
  localparam int                TAIL_CYCLES    = 40;
  localparam int                MAX_SHOWN      = 10;
  localparam int                CNT_MAX        = (1 << CNT_W) - 1;
  localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  // DUT signals
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req_item  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp_item;

  // Shadow state of the feeder
  logic [BYTE_W-1:0] shadow_ring [RING_DEPTH];
  logic [PTR_W-1:0]  shadow_wr     = '0;
  logic [PTR_W-1:0]  shadow_rd     = '0;
  logic              shadow_irq_en = 1'b0;

  // Responses still owed by the DUT, oldest first
  out_item_t due_results [$];

  // Bookkeeping
  int n_items      = 0;
  int n_results    = 0;
  int n_direct     = 0;
  int n_drops      = 0;
  int n_drained    = 0;
  int n_errors     = 0;
  int n_bp_cycles  = 0;
  int peak_fill    = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;

  // Response stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_tick = 0;
  logic        stall_pick;
  logic        hold_on    = 1'b0;
  event        hold_ev;

  tx_ring_buffer_fifo_feeder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------

  function automatic int ring_fill();
    logic [PTR_W-1:0] used;
    used = shadow_wr - shadow_rd;
    return int'(used);
  endfunction

  // Computes the response transfers of one request and queues them as due
  function automatic void feed_step_results(input in_item_t req);
    out_item_t        step_q [$];
    out_item_t        res;
    logic [PTR_W-1:0] next_wr;
    int               fifo_fill;
    res       = '0;
    fifo_fill = int'(req.fifo_count);
    case (req.opcode)
      OP_PUT: begin
        next_wr = shadow_wr + 1'b1;
        if (fifo_fill < FIFO_DEPTH) begin
          res.fifo_write = 1'b1;
          res.fifo_byte  = req.data_byte;
          n_direct++;
        end else if (next_wr == shadow_rd) begin
          res.dropped = 1'b1;
          n_drops++;
        end else begin
          shadow_ring[shadow_wr] = req.data_byte;
          shadow_wr              = next_wr;
          shadow_irq_en          = 1'b1;
        end
        step_q.push_back(res);
      end
      OP_POLL, OP_IRQ: begin
        // oldest bytes first, until FIFO full, ring empty or the per-request cap
        while (shadow_rd != shadow_wr && fifo_fill < FIFO_DEPTH &&
               step_q.size() < MAX_RESULTS) begin
          res.fifo_write = 1'b1;
          res.fifo_byte  = shadow_ring[shadow_rd];
          step_q.push_back(res);
          shadow_rd = shadow_rd + 1'b1;
          fifo_fill++;
          n_drained++;
        end
        if (req.opcode == OP_POLL && shadow_rd != shadow_wr) shadow_irq_en = 1'b1;
        if (req.opcode == OP_IRQ && shadow_rd == shadow_wr) shadow_irq_en = 1'b0;
        if (step_q.size() == 0) step_q.push_back('0);
      end
      default: begin
        step_q.push_back(res);
      end
    endcase
    // status fields reflect the end of the step on every transfer
    foreach (step_q[i]) begin
      step_q[i].last_result  = (i == step_q.size() - 1);
      step_q[i].irq_enabled  = shadow_irq_en;
      step_q[i].queued_count = QCNT_W'(ring_fill());
      due_results.push_back(step_q[i]);
    end
    if (ring_fill() > peak_fill) peak_fill = ring_fill();
  endfunction

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("wr=%0b byte=%02h last=%0b drop=%0b irq=%0b queued=%0d",
                     r.fifo_write, r.fifo_byte, r.last_result, r.dropped,
                     r.irq_enabled, r.queued_count);
  endfunction

  // --------------------------------------------------------------------------
  // Response checking and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_item_t want;
    logic      moved;
    if (!rst) begin
      moved = 1'b0;
      if (req_valid && !req_stall) moved = 1'b1;
      if (req_valid && req_stall) n_bp_cycles++;
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        n_results++;
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: unexpected response: %s", $time, fmt_result(rsp_item));
        end else begin
          want = due_results.pop_front();
          if (rsp_item.fifo_write   !== want.fifo_write   ||
              rsp_item.fifo_byte    !== want.fifo_byte    ||
              rsp_item.last_result  !== want.last_result  ||
              rsp_item.dropped      !== want.dropped      ||
              rsp_item.irq_enabled  !== want.irq_enabled  ||
              rsp_item.queued_count !== want.queued_count) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("%0t: mismatch: expected %s, got %s", $time,
                       fmt_result(want), fmt_result(rsp_item));
          end
        end
      end
      // watchdog on cycles without any transfer
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                 $time, idle_cycles, due_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side stalls
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    stall_tick = stall_tick + 1;
    if (stall_tick % 89 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     stall_pick = 1'b0;
      STALL_RANDOM:   stall_pick = ($urandom_range(0, 99) < 35);
      STALL_PERIODIC: stall_pick = (stall_tick % 4 == 0);
      default:        stall_pick = ($urandom_range(0, 99) < 85);
    endcase
    rsp_stall <= hold_on || stall_pick;
  end

  // long hold-off, counted on the falling edge
  always begin
    @(hold_ev);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  function automatic in_item_t make_req(input logic [OP_W-1:0] op,
                                        input logic [BYTE_W-1:0] data,
                                        input int count);
    in_item_t req;
    req.opcode     = op;
    req.data_byte  = data;
    req.fifo_count = CNT_W'(count);
    return req;
  endfunction

  // Sends one request in bursts with random gaps; returns at its transfer
  task automatic send_req(input in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_item  <= req;
    do @(posedge clk); while (req_stall);
    n_items++;
    feed_step_results(req);
  endtask

  // Drops valid and waits until every owed response has arrived
  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic in_item_t rand_req(input int full_pct);
    int       pick;
    in_item_t req;
    req  = make_req(OP_PUT, 8'($urandom_range(0, 255)), 0);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.opcode     = OP_PUT;
      req.fifo_count = ($urandom_range(0, 99) < full_pct)
                       ? CNT_W'($urandom_range(FIFO_DEPTH, CNT_MAX))
                       : CNT_W'($urandom_range(0, FIFO_DEPTH - 1));
    end else begin
      if (pick < 73)      req.opcode = OP_POLL;
      else if (pick < 95) req.opcode = OP_IRQ;
      else                req.opcode = OP_UNUSED;
      req.fifo_count = ($urandom_range(0, 99) < 60) ? CNT_W'($urandom_range(0, 3))
                                                    : CNT_W'($urandom_range(0, CNT_MAX));
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Puts that go straight to the FIFO, byte and count extremes
  task automatic test_direct_writes();
    send_req(make_req(OP_PUT, 8'h00, 0));
    send_req(make_req(OP_PUT, 8'hFF, FIFO_DEPTH - 1));
    send_req(make_req(OP_PUT, 8'hA5, 4));
    wait_idle();
  endtask

  // Queueing, bypass with a non-empty ring, status-only drains, unused opcode
  task automatic test_queue_paths();
    send_req(make_req(OP_PUT, 8'h11, FIFO_DEPTH));
    send_req(make_req(OP_PUT, 8'h22, CNT_MAX));
    send_req(make_req(OP_PUT, 8'h33, FIFO_DEPTH + 1));
    send_req(make_req(OP_PUT, 8'h44, 12));
    send_req(make_req(OP_PUT, 8'h55, FIFO_DEPTH));
    send_req(make_req(OP_PUT, 8'h66, 0));             // bypass while ring holds
    send_req(make_req(OP_POLL, 8'h00, CNT_MAX));      // FIFO full: status only
    send_req(make_req(OP_POLL, 8'h00, FIFO_DEPTH - 2));
    send_req(make_req(OP_IRQ, 8'h00, FIFO_DEPTH));    // nothing moves, enable kept
    send_req(make_req(OP_IRQ, 8'h00, 0));             // empties ring, clears enable
    send_req(make_req(OP_IRQ, 8'h00, 0));             // empty ring
    send_req(make_req(OP_POLL, 8'h00, 0));            // empty ring, no change
    send_req(make_req(OP_UNUSED, 8'hFF, CNT_MAX));
    wait_idle();
  endtask

  // Fill the ring to depth minus one, drop, then drain in capped steps
  task automatic test_ring_full();
    int room;
    wait_idle();
    room = RING_DEPTH - 1 - ring_fill();
    for (int k = 0; k < room; k++)
      send_req(make_req(OP_PUT, 8'($urandom_range(0, 255)),
                        $urandom_range(FIFO_DEPTH, CNT_MAX)));
    send_req(make_req(OP_POLL, 8'h00, FIFO_DEPTH));
    send_req(make_req(OP_PUT, 8'h00, FIFO_DEPTH));
    send_req(make_req(OP_PUT, 8'hFF, CNT_MAX));
    send_req(make_req(OP_PUT, 8'($urandom_range(0, 255)), 12));
    send_req(make_req(OP_PUT, 8'h5A, 0));
    while (ring_fill() != 0)
      send_req(make_req(OP_IRQ, 8'h00, $urandom_range(0, 2)));
    send_req(make_req(OP_IRQ, 8'h00, 0));
    wait_idle();
  endtask

  // Responses held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    -> hold_ev;
    for (int k = 0; k < 40; k++) send_req(rand_req(70));
    wait_idle();
  endtask

  // Random traffic; each segment leans toward filling or draining the ring
  task automatic test_random_traffic();
    int full_pct;
    full_pct = 70;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       full_pct = 30;
          1:       full_pct = 70;
          default: full_pct = 95;
        endcase
      end
      send_req(rand_req(full_pct));
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_direct_writes();
    test_queue_paths();
    test_ring_full();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      n_errors += due_results.size();
      $display("%0d responses never arrived", due_results.size());
    end

    $display("Ran %0d requests: %0d direct writes, %0d bytes drained, %0d drops, ring peak %0d",
             n_items, n_direct, n_drained, n_drops, peak_fill);
    $display("Checked %0d responses, request back-pressure on %0d cycles, %0d errors",
             n_results, n_bp_cycles, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/txrb_pkg.sv
rtl/txrb_ring_mem.sv
rtl/txrb_seq.sv
rtl/tx_ring_buffer_fifo_feeder_core.sv
dv/tb_tx_ring_buffer_fifo_feeder_core.sv
